// File: rtl/core/scfp_pkg.sv
// Package: shared types and constants for the serial command frame parser.
`default_nettype none
package scfp_pkg;
  localparam int unsigned FrameLen = 7;
  localparam logic [7:0] StartChar = 8'h3C;
  localparam logic [7:0] EndChar = 8'h0A;
  localparam logic [7:0] LabelSet = 8'h63;
  localparam logic [7:0] LabelStop = 8'h61;
  localparam logic [7:0] TimeoutReset = 8'd50;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_SET = 3'd1,
    EV_STOP = 3'd2,
    EV_OTHER = 3'd3,
    EV_TIMEOUT = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_SET = 2'd1,
    OP_STOP = 2'd2,
    OP_OTHER = 2'd3
  } frame_op_t;

  // Classified request passed from front to back.
  typedef struct packed {
    logic tick;
    frame_op_t op;
    logic [31:0] bits;
  } req_t;

  // Truncate IEEE single bits toward zero, saturating to signed 32 bits.
  function automatic logic [31:0] trunc_sat(input logic [31:0] b);
    logic neg;
    logic [7:0] ex;
    logic [22:0] man;
    logic [7:0] sh;
    logic [31:0] mag;
    logic [31:0] res;
    neg = b[31];
    ex = b[30:23];
    man = b[22:0];
    sh = ex - 8'd127;
    mag = {8'd0, 1'b1, man};
    if (ex == 8'hFF) begin
      res = (man != 23'd0) ? 32'd0 : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end else if (ex < 8'd127) begin
      res = 32'd0;
    end else if (sh >= 8'd31) begin
      res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      if (sh >= 8'd23) mag = mag << sh[4:0] - 5'd23;
      else mag = mag >> (5'd23 - sh[4:0]);
      res = neg ? (32'd0 - mag) : mag;
    end
    return res;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/scfp_front.sv
// Front end: frame assembly and classification of each request.
`default_nettype none
module scfp_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  input  wire logic in_tuser,
  input  wire logic [7:0] in_tdata,
  output logic q_valid,
  input  wire logic q_ready,
  output scfp_pkg::req_t q_req
);
  logic [2:0] frame_index_r, frame_index_nxt;
  logic [7:0] store_r [0:5];
  logic acc;
  logic closes;

  assign in_tready = q_ready;
  assign q_valid = in_tvalid;
  assign acc = in_tvalid && q_ready;
  // byte that fills the last position
  assign closes = !in_tuser && in_tdata != scfp_pkg::StartChar && frame_index_r == 3'd6;

  always_comb begin
    q_req.tick = in_tuser;
    q_req.bits = {store_r[5], store_r[4], store_r[3], store_r[2]};
    q_req.op = scfp_pkg::OP_NONE;
    if (closes && store_r[0] == scfp_pkg::StartChar && in_tdata == scfp_pkg::EndChar) begin
      if (store_r[1] == scfp_pkg::LabelSet) q_req.op = scfp_pkg::OP_SET;
      else if (store_r[1] == scfp_pkg::LabelStop) q_req.op = scfp_pkg::OP_STOP;
      else q_req.op = scfp_pkg::OP_OTHER;
    end
  end

  always_comb begin
    frame_index_nxt = frame_index_r;
    if (acc && !in_tuser) begin
      if (in_tdata == scfp_pkg::StartChar) frame_index_nxt = 3'd1;
      else if (frame_index_r >= 3'd6) frame_index_nxt = 3'd0;
      else frame_index_nxt = frame_index_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) frame_index_r <= 3'd0;
    else frame_index_r <= frame_index_nxt;
  end

  always_ff @(posedge clk) begin
    if (acc && !in_tuser) begin
      if (in_tdata == scfp_pkg::StartChar) store_r[0] <= scfp_pkg::StartChar;
      else if (frame_index_r < 3'd6) store_r[frame_index_r] <= in_tdata;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) frame_index_r != 3'd7)
    else $error("frame index out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_tuser && in_tdata == scfp_pkg::StartChar) |=> frame_index_r == 3'd1)
    else $error("start byte did not restart frame");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tuser |-> q_req.op == scfp_pkg::OP_NONE)
    else $error("tick classified as frame");
endmodule
`default_nettype wire

// File: rtl/core/scfp_queue.sv
// Short request queue between front and back.
`default_nettype none
module scfp_queue #(
  parameter int unsigned Depth = scfp_pkg::QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic wr_ready,
  input  wire scfp_pkg::req_t wr_req,
  output logic rd_valid,
  input  wire logic rd_ready,
  output scfp_pkg::req_t rd_req
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  scfp_pkg::req_t mem_r [0:Depth-1];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != Depth[AW:0];
  assign rd_valid = cnt_r != '0;
  assign rd_req = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_req;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= Depth[AW:0])
    else $error("queue overflow");
endmodule
`default_nettype wire

// File: rtl/core/scfp_back.sv
// Back end: state registers, watchdog and result register.
`default_nettype none
module scfp_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [7:0] timeout_ticks,
  input  wire logic q_valid,
  output logic q_ready,
  input  wire scfp_pkg::req_t q_req,
  output logic out_tvalid,
  input  wire logic out_tready,
  output logic [87:0] out_tdata
);
  logic [7:0] timer_r, timer_nxt, timer_inc;
  logic [31:0] set_r, set_nxt, stop_r, stop_nxt;
  logic [15:0] cnt_r, cnt_nxt, cnt_up;
  logic tog_r, tog_nxt;
  logic [2:0] ev;
  logic valid_r;
  logic [87:0] data_r;
  logic take;

  assign q_ready = !valid_r || out_tready;
  assign take = q_valid && q_ready;
  assign out_tvalid = valid_r;
  assign out_tdata = data_r;
  assign timer_inc = timer_r + 8'd1;
  assign cnt_up = (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;

  always_comb begin
    timer_nxt = timer_r; set_nxt = set_r; stop_nxt = stop_r;
    cnt_nxt = cnt_r; tog_nxt = tog_r; ev = scfp_pkg::EV_NONE;
    if (q_req.tick) begin
      timer_nxt = timer_inc;
      if (timer_inc >= timeout_ticks || timer_inc == 8'd0) begin
        timer_nxt = 8'd0; set_nxt = 32'd0; tog_nxt = !tog_r;
        ev = scfp_pkg::EV_TIMEOUT;
      end
    end else begin
      timer_nxt = 8'd0;
      unique case (q_req.op)
        scfp_pkg::OP_SET: begin
          set_nxt = q_req.bits; cnt_nxt = cnt_up; ev = scfp_pkg::EV_SET;
        end
        scfp_pkg::OP_STOP: begin
          stop_nxt = scfp_pkg::trunc_sat(q_req.bits); cnt_nxt = 16'd0;
          ev = scfp_pkg::EV_STOP;
        end
        scfp_pkg::OP_OTHER: begin
          cnt_nxt = cnt_up; ev = scfp_pkg::EV_OTHER;
        end
        default: ev = scfp_pkg::EV_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0; set_r <= '0; stop_r <= '0; cnt_r <= '0; tog_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (take) begin
        timer_r <= timer_nxt; set_r <= set_nxt; stop_r <= stop_nxt;
        cnt_r <= cnt_nxt; tog_r <= tog_nxt;
      end
      if (q_ready) valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) data_r <= {4'd0, tog_nxt, cnt_nxt, stop_nxt, set_nxt, ev};
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (take && q_req.tick && ev == scfp_pkg::EV_TIMEOUT) |=> set_r == 32'd0)
    else $error("timeout did not clear setpoint");
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && !q_req.tick) |=> timer_r == 8'd0)
    else $error("byte did not clear watchdog");
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_tready) |=> valid_r)
    else $error("result dropped");
endmodule
`default_nettype wire

// File: rtl/core/serial_command_frame_parser_top.sv
// Top level of the serial command frame parser.
`default_nettype none
// Takes one request per cycle while out_tready is high: a received serial byte (in_tuser = 0) or a
// control tick (in_tuser = 1), and returns exactly one result per request.
// Bytes build a 7-byte frame '<', label, four little-endian IEEE single
// bytes, '\n'; a '<' always restarts the frame. Label 'c' loads the setpoint,
// 'a' loads the truncated, saturated stop value and clears the frame count.
// Ticks run a link watchdog that clears the setpoint after timeout_ticks
// ticks without a byte (0 acts as 1) and toggles the timeout flag.
// Rate: one request per clock sustained while out_tready is high; requests pass through the
// combinational front classifier, a 2-entry request queue and the registered back end.
// Write cfg only while idle.
module serial_command_frame_parser_top #(
  parameter int unsigned QueueDepth = scfp_pkg::QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  input  wire logic in_tuser,          // command: 0 byte, 1 tick
  input  wire logic [7:0] in_tdata,    // rx_byte
  output logic out_tvalid,
  input  wire logic out_tready,
  // [2:0] event_res, [34:3] setpoint_bits, [66:35] stop_value,
  // [82:67] frame_count, [83] timeout_flag, [87:84] zero
  output logic [87:0] out_tdata,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [7:0] cfg_data     // timeout_ticks
);
  logic [7:0] timeout_r;
  logic f_valid, f_ready, b_valid, b_ready;
  scfp_pkg::req_t f_req, b_req;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) timeout_r <= scfp_pkg::TimeoutReset;
    else if (cfg_valid) timeout_r <= cfg_data;
  end

  scfp_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .q_valid(f_valid), .q_ready(f_ready), .q_req(f_req)
  );

  scfp_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_req(f_req),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_req(b_req)
  );

  scfp_back u_back (
    .clk, .rst_n, .timeout_ticks(timeout_r),
    .q_valid(b_valid), .q_ready(b_ready), .q_req(b_req),
    .out_tvalid, .out_tready, .out_tdata
  );
endmodule
`default_nettype wire
